// ----- hdl/lz77_pkg.sv -----
// Shared types and constants of the LZ77 greedy token encoder.
`timescale 1ns / 1ps
package lz77_pkg;

    localparam int DEF_WINDOW_SIZE = 1024;
    localparam int DEF_MAX_MATCH   = 64;
    localparam int DEF_RING_DEPTH  = 2048;

    localparam int OFFSET_W = 11;
    localparam int LENGTH_W = 7;
    localparam int BYTE_W   = 8;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // One queued command: a text byte or an end-of-text marker.
    typedef struct packed {
        logic              eot;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // One finished token.
    typedef struct packed {
        logic                is_match;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [BYTE_W-1:0]   next_byte;
        logic                has_next;
        logic                last;
    } t_token;

endpackage

// ----- hdl/lz77_front.sv -----
// Input side: accept stream transactions, classify them and queue commands.
`timescale 1ns / 1ps
module lz77_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lz77_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output lz77_pkg::t_cmd                  o_cmd
);
    import lz77_pkg::*;

    t_cmd                 r_queue [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_PTR_W:0]   r_count, n_count;
    logic                 w_push, w_pop;
    t_cmd                 w_cmd;

    assign o_s_axis_tready = (r_count != CMD_PTR_W'(0) + (CMD_PTR_W+1)'(CMD_DEPTH));
    assign w_push = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop  = o_cmd_valid && i_cmd_ready;
    assign o_cmd  = r_queue[r_rd_ptr];

    // An end marker carries no byte.
    always_comb begin
        w_cmd.eot  = i_s_axis_tlast;
        w_cmd.data = i_s_axis_tlast ? '0 : i_s_axis_tdata[BYTE_W-1:0];
    end

    always_comb begin
        n_wr_ptr = w_push ? CMD_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? CMD_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ----- hdl/lz77_back.sv -----
// Execution side: byte ring, greedy match search and token output register.
`timescale 1ns / 1ps
module lz77_back #(
    parameter int WINDOW_SIZE = lz77_pkg::DEF_WINDOW_SIZE,
    parameter int MAX_MATCH   = lz77_pkg::DEF_MAX_MATCH,
    parameter int RING_DEPTH  = lz77_pkg::DEF_RING_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  lz77_pkg::t_cmd   i_cmd,
    output logic             o_tok_valid,
    input  logic             i_tok_ready,
    output lz77_pkg::t_token o_tok
);
    import lz77_pkg::*;

    localparam int LIM_MATCH  = (MAX_MATCH < RING_DEPTH - 1) ? MAX_MATCH : RING_DEPTH - 1;
    localparam int RING_SPARE = RING_DEPTH - LIM_MATCH - 1;
    localparam int LIM_WINDOW = (WINDOW_SIZE < RING_SPARE) ? WINDOW_SIZE : RING_SPARE;
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int LW  = $clog2(LIM_MATCH + 1);
    localparam int PW  = $clog2(LIM_MATCH + 2);
    localparam int HW  = $clog2(LIM_WINDOW + 1);
    localparam int SW  = $clog2(LIM_WINDOW + LIM_MATCH + 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [BYTE_W-1:0] r_qa, r_qb;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_start, n_start;
    logic [PW-1:0] r_pend, n_pend;
    logic [HW-1:0] r_hist, n_hist;
    logic          r_flush, n_flush;
    logic [LW-1:0] r_limit, n_limit;
    logic [HW-1:0] r_off, n_off;
    logic [AW-1:0] r_obase, n_obase;
    logic [AW-1:0] r_pa, n_pa;
    logic [AW-1:0] r_pb, n_pb;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_best, n_best;
    logic [HW-1:0] r_best_off, n_best_off;
    logic          r_tok_valid, n_tok_valid;
    t_token        r_tok, n_tok;

    logic          w_wr_en;
    logic [AW-1:0] w_addr_a;
    logic [AW-1:0] w_fetch_addr;
    logic [AW:0]   w_fetch_sum;
    logic [AW-1:0] w_obase_dec;
    logic          w_has;
    logic [PW-1:0] w_used;
    logic [AW:0]   w_start_sum;
    logic [SW-1:0] w_hist_sum;
    logic [LW-1:0] w_len_f;
    logic [PW-1:0] w_pend_p1;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(RING_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(RING_DEPTH - 1) : AW'(p - 1'b1);
    endfunction

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    assign w_obase_dec  = ptr_dec(r_obase);
    assign w_fetch_sum  = (AW+1)'(r_start) + (AW+1)'(r_best);
    assign w_fetch_addr = (w_fetch_sum >= (AW+1)'(RING_DEPTH)) ?
                          AW'(w_fetch_sum - (AW+1)'(RING_DEPTH)) : AW'(w_fetch_sum);
    assign w_addr_a     = (r_state == ST_FETCH) ? w_fetch_addr : r_pa;
    assign w_pend_p1    = PW'(r_pend + 1'b1);

    // A literal has best length zero, so "has next" covers it too.
    assign w_has       = (PW'(r_best) < r_pend);
    assign w_used      = PW'(r_best) + PW'(w_has);
    assign w_start_sum = (AW+1)'(r_start) + (AW+1)'(w_used);
    assign w_hist_sum  = SW'(r_hist) + SW'(w_used);
    assign w_len_f     = (r_qa == r_qb) ? LW'(r_len + 1'b1) : r_len;

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_start     = r_start;
        n_pend      = r_pend;
        n_hist      = r_hist;
        n_flush     = r_flush;
        n_limit     = r_limit;
        n_off       = r_off;
        n_obase     = r_obase;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_len       = r_len;
        n_best      = r_best;
        n_best_off  = r_best_off;
        n_tok_valid = r_tok_valid;
        n_tok       = r_tok;
        w_wr_en     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.eot) begin
                        w_wr_en = 1'b1;
                        n_wptr  = ptr_inc(r_wptr);
                        n_pend  = w_pend_p1;
                        n_flush = 1'b0;
                        if (w_pend_p1 >= PW'(LIM_MATCH + 1)) begin
                            n_state = ST_SETUP;
                        end
                    end else if (r_pend == '0) begin
                        n_hist = '0;
                    end else begin
                        n_flush = 1'b1;
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_limit    = (r_pend < PW'(LIM_MATCH)) ? LW'(r_pend) : LW'(LIM_MATCH);
                n_best     = '0;
                n_best_off = '0;
                n_off      = HW'(1);
                n_obase    = ptr_dec(r_start);
                n_pa       = r_start;
                n_pb       = ptr_dec(r_start);
                n_len      = '0;
                n_state    = (r_hist == '0) ? ST_FETCH : ST_READ;
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if ((r_qa == r_qb) && (w_len_f != r_limit)) begin
                    // Extend the current run by one byte.
                    n_len   = w_len_f;
                    n_pa    = ptr_inc(r_pa);
                    n_pb    = ptr_inc(r_pb);
                    n_state = ST_READ;
                end else begin
                    // Keep strictly longer runs only: ties go to the smaller offset.
                    if (w_len_f > r_best) begin
                        n_best     = w_len_f;
                        n_best_off = r_off;
                    end
                    if (r_off == r_hist) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_off   = HW'(r_off + 1'b1);
                        n_obase = w_obase_dec;
                        n_pa    = r_start;
                        n_pb    = w_obase_dec;
                        n_len   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_tok.is_match  = (r_best != '0);
                n_tok.offset    = OFFSET_W'(r_best_off);
                n_tok.length    = LENGTH_W'(r_best);
                n_tok.next_byte = w_has ? r_qa : '0;
                n_tok.has_next  = w_has;
                n_tok.last      = !r_flush || (r_pend == w_used);
                n_tok_valid     = 1'b1;
                n_pend          = PW'(r_pend - w_used);
                n_start         = (w_start_sum >= (AW+1)'(RING_DEPTH)) ?
                                  AW'(w_start_sum - (AW+1)'(RING_DEPTH)) : AW'(w_start_sum);
                n_hist          = (w_hist_sum > SW'(LIM_WINDOW)) ?
                                  HW'(LIM_WINDOW) : HW'(w_hist_sum);
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_tok_ready) begin
                    n_tok_valid = 1'b0;
                    if (!r_flush) begin
                        n_state = ST_IDLE;
                    end else if (r_pend != '0) begin
                        n_state = ST_SETUP;
                    end else begin
                        n_hist  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wptr      <= '0;
            r_start     <= '0;
            r_pend      <= '0;
            r_hist      <= '0;
            r_flush     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_start     <= n_start;
            r_pend      <= n_pend;
            r_hist      <= n_hist;
            r_flush     <= n_flush;
            r_tok_valid <= n_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit    <= n_limit;
        r_off      <= n_off;
        r_obase    <= n_obase;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_len      <= n_len;
        r_best     <= n_best;
        r_best_off <= n_best_off;
        r_tok      <= n_tok;
    end

    // Byte ring: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[r_wptr] <= i_cmd.data;
        end
        r_qa <= r_ring[w_addr_a];
        r_qb <= r_ring[r_pb];
    end

endmodule

// ----- hdl/lz77_greedy_token_encoder_unit.sv -----
// Top level of the greedy LZ77 token encoder.
// Usage:
//   Slave stream: one text byte per transaction in tdata[7:0]; a transaction
//   with tlast high is an end-of-text marker (tdata ignored) that flushes all
//   pending bytes as tokens and starts a new, empty text.
//   Master stream: one token per transaction. tuser is the match flag;
//   tlast marks the final token caused by one input transaction.
//   The history window is up to WINDOW_SIZE bytes, matches are up to
//   MAX_MATCH bytes; a token is made once MAX_MATCH+1 bytes are pending.
// Search and queueing:
//   A byte that makes no token is written to the ring and counted as pending.
//   For a token the search walks every offset of the history and compares
//   one byte pair per read of the two ring read ports, stopping each offset
//   at its first mismatch or at the match limit. The back end takes no new
//   command until its token is taken.
//   A 4-entry command queue keeps accepting input while the search runs, until it is full.
// Reset: synchronous, active low; clears history, pending count and queues.
// The ring contents need no reset. A stalled receiver holds the token in the
// output register; the search stops until it is taken.
`timescale 1ns / 1ps
module lz77_greedy_token_encoder_unit #(
    parameter int WINDOW_SIZE = lz77_pkg::DEF_WINDOW_SIZE,
    parameter int MAX_MATCH   = lz77_pkg::DEF_MAX_MATCH,
    parameter int RING_DEPTH  = lz77_pkg::DEF_RING_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [lz77_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // end_of_text
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [10:0] match_offset, [17:11] match_length, [25:18] next_byte,
    // [26] has_next_byte, [31:27] zero
    output logic [lz77_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tuser,  // is_match
    output logic                             o_m_axis_tlast   // last_token
);
    import lz77_pkg::*;

    logic   w_cmd_valid;
    logic   w_cmd_ready;
    t_cmd   w_cmd;
    t_token w_tok;

    // Front: accept and classify each transaction into the command queue.
    lz77_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_cmd_valid     (w_cmd_valid),
        .i_cmd_ready     (w_cmd_ready),
        .o_cmd           (w_cmd)
    );

    // Back: store bytes, search the window and emit tokens.
    lz77_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_MATCH   (MAX_MATCH),
        .RING_DEPTH  (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_tok_valid (o_m_axis_tvalid),
        .i_tok_ready (i_m_axis_tready),
        .o_tok       (w_tok)
    );

    // Pack the token fields, lowest field first, zero fill to 32 bits.
    assign o_m_axis_tdata = {5'd0, w_tok.has_next, w_tok.next_byte,
                             w_tok.length, w_tok.offset};
    assign o_m_axis_tuser = w_tok.is_match;
    assign o_m_axis_tlast = w_tok.last;

endmodule
